// ===== sv/jddm_pkg.sv =====
// Package: widths, constants, register map and beat types for the joystick drive mixer.
package jddm_pkg;

   localparam int ADC_BITS  = 12;
   localparam int DUTY_BITS = 8;

   localparam int AMAX = (1 << ADC_BITS) - 1;
   localparam int DMAX = (1 << DUTY_BITS) - 1;

   localparam int TIME_W       = 32;
   localparam int DEBOUNCE_W   = 16;
   localparam int DEADBAND_W   = 8;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;

   // raw * 2*DMAX / AMAX done as (raw * MAP_RECIP) >> MAP_SHIFT, exact for raw <= AMAX
   localparam int MAP_SHIFT   = 2 * ADC_BITS;
   localparam int MAP_RECIP_W = DUTY_BITS + ADC_BITS + 2;
   localparam int MAP_PROD_W  = ADC_BITS + MAP_RECIP_W;
   localparam longint unsigned MAP_RECIP =
      ((64'(2 * DMAX) << MAP_SHIFT) + 64'(AMAX) - 64'd1) / 64'(AMAX);

   localparam int AXIS_W = DUTY_BITS + 2;
   localparam int MIX_W  = AXIS_W + 1;

   localparam logic REG_DEBOUNCE = 1'b0;
   localparam logic REG_DEADBAND = 1'b1;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(30);
   localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = DEADBAND_W'(20);

   typedef struct packed {
      logic [TIME_W-1:0]   time_ms;
      logic                button_level;
      logic [ADC_BITS-1:0] joy_x;
      logic [ADC_BITS-1:0] joy_y;
   } req_type;

   typedef struct packed {
      logic [DUTY_BITS-1:0] left_forward;
      logic [DUTY_BITS-1:0] left_reverse;
      logic [DUTY_BITS-1:0] right_forward;
      logic [DUTY_BITS-1:0] right_reverse;
      logic                 drive_enabled;
   } rsp_type;

   typedef struct packed {
      logic [DEBOUNCE_W-1:0] debounce_ms;
      logic [DEADBAND_W-1:0] deadband_limit;
   } cfg_type;

endpackage

// ===== sv/jddm_csr.sv =====
// Configuration registers behind the APB-style port.
module jddm_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [jddm_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [jddm_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [jddm_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output jddm_pkg::cfg_type                cfg
);

   logic [jddm_pkg::DEBOUNCE_W-1:0] debounce_ff, debounce_in;
   logic [jddm_pkg::DEADBAND_W-1:0] deadband_ff, deadband_in;
   logic                            wr_en;
   logic                            reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[jddm_pkg::CSR_ADDR_W-1];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      debounce_in = debounce_ff;
      deadband_in = deadband_ff;
      if (wr_en) begin
         case (reg_sel)
            jddm_pkg::REG_DEBOUNCE: debounce_in = csr_pwdata[jddm_pkg::DEBOUNCE_W-1:0];
            jddm_pkg::REG_DEADBAND: deadband_in = csr_pwdata[jddm_pkg::DEADBAND_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= jddm_pkg::DEBOUNCE_RESET;
         deadband_ff <= jddm_pkg::DEADBAND_RESET;
      end else begin
         debounce_ff <= debounce_in;
         deadband_ff <= deadband_in;
      end
   end

   always_comb begin
      case (reg_sel)
         jddm_pkg::REG_DEBOUNCE: csr_prdata = jddm_pkg::CSR_DATA_W'(debounce_ff);
         jddm_pkg::REG_DEADBAND: csr_prdata = jddm_pkg::CSR_DATA_W'(deadband_ff);
         default:                csr_prdata = '0;
      endcase
   end

   assign cfg.debounce_ms    = debounce_ff;
   assign cfg.deadband_limit = deadband_ff;

endmodule

// ===== sv/jddm_debounce.sv =====
// Timestamp debounce of the button and the press-toggled drive enable.
module jddm_debounce (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [jddm_pkg::TIME_W-1:0]      time_ms,
   input  logic                             button_level,
   input  logic [jddm_pkg::DEBOUNCE_W-1:0]  debounce_ms,
   output logic                             enable_next
);

   logic                          prev_ff, prev_in;
   logic                          stable_ff, stable_in;
   logic [jddm_pkg::TIME_W-1:0]   last_ff, last_in;
   logic                          en_ff, en_in;
   logic [jddm_pkg::TIME_W-1:0]   last_new;
   logic [jddm_pkg::TIME_W-1:0]   elapsed;
   logic                          settle;

   always_comb begin
      last_new  = (button_level != prev_ff) ? time_ms : last_ff;
      elapsed   = time_ms - last_new;
      settle    = (elapsed > jddm_pkg::TIME_W'(debounce_ms)) && (button_level != stable_ff);
      prev_in   = prev_ff;
      stable_in = stable_ff;
      last_in   = last_ff;
      en_in     = en_ff;
      if (accept) begin
         prev_in = button_level;
         last_in = last_new;
         if (settle) begin
            stable_in = button_level;
            if (!button_level) begin
               en_in = !en_ff;
            end
         end
      end
   end

   // enable as seen by the sample being accepted
   assign enable_next = (settle && !button_level) ? !en_ff : en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= 1'b1;
         stable_ff <= 1'b1;
         last_ff   <= '0;
         en_ff     <= 1'b0;
      end else begin
         prev_ff   <= prev_in;
         stable_ff <= stable_in;
         last_ff   <= last_in;
         en_ff     <= en_in;
      end
   end

   a_toggle_on_press: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (en_ff != $past(en_ff))) |-> ($past(stable_ff) && !stable_ff))
      else $error("enable toggled without an accepted press");

endmodule

// ===== sv/jddm_axis.sv =====
// One joystick axis: scale to +-DMAX by reciprocal multiply, center, apply deadband.
module jddm_axis (
   input  logic [jddm_pkg::ADC_BITS-1:0]         raw,
   input  logic [jddm_pkg::DEADBAND_W-1:0]       deadband_limit,
   output logic signed [jddm_pkg::AXIS_W-1:0]    mapped
);

   localparam logic [jddm_pkg::MAP_PROD_W-1:0] RECIP =
      jddm_pkg::MAP_PROD_W'(jddm_pkg::MAP_RECIP);
   localparam logic signed [jddm_pkg::AXIS_W-1:0] CENTER =
      jddm_pkg::AXIS_W'(jddm_pkg::DMAX);

   logic [jddm_pkg::MAP_PROD_W-1:0]        prod;
   logic [jddm_pkg::DUTY_BITS:0]           quot;
   logic signed [jddm_pkg::AXIS_W-1:0]     centered;
   logic [jddm_pkg::AXIS_W-1:0]            mag;

   always_comb begin
      prod     = jddm_pkg::MAP_PROD_W'(raw) * RECIP;
      quot     = prod[jddm_pkg::MAP_SHIFT +: jddm_pkg::DUTY_BITS + 1];
      centered = signed'({1'b0, quot}) - CENTER;
      mag      = centered[jddm_pkg::AXIS_W-1] ? unsigned'(-centered) : unsigned'(centered);
      mapped   = (mag <= jddm_pkg::AXIS_W'(deadband_limit)) ? '0 : centered;
   end

endmodule

// ===== sv/joystick_differential_drive_mixer_core.sv =====
// Joystick differential-drive mixer: top level with the input and result registers.
// One sample beat is taken every cycle while req_stall is low. Its result beat passes
// through the input register and then the result register, and rsp_stall can hold it. The button
// debounce and enable toggle settle at acceptance into the input register. Both axes are
// then scaled and deadbanded, mixed left/right, saturated and split into forward/reverse
// duties in one combinational pass into the result register. The input register holds only
// while the result register is full and stalled, so req_stall rises only when both are full
// and rsp_stall is high. Configuration is read live, so write it only while no beat is in flight.
module joystick_differential_drive_mixer_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  jddm_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output jddm_pkg::rsp_type                rsp_payload,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [jddm_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [jddm_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [jddm_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   localparam int D = jddm_pkg::DUTY_BITS;
   localparam logic signed [jddm_pkg::MIX_W-1:0] SAT_HI = jddm_pkg::MIX_W'(jddm_pkg::DMAX);
   localparam logic signed [jddm_pkg::MIX_W-1:0] SAT_LO = -SAT_HI;

   typedef struct packed {
      logic [D-1:0] fwd;
      logic [D-1:0] rev;
   } side_type;

   function automatic side_type split_side(input logic signed [jddm_pkg::MIX_W-1:0] v);
      logic signed [jddm_pkg::MIX_W-1:0] s;
      logic signed [jddm_pkg::MIX_W-1:0] neg;
      side_type r;
      if (v > SAT_HI) begin
         s = SAT_HI;
      end else if (v < SAT_LO) begin
         s = SAT_LO;
      end else begin
         s = v;
      end
      neg = -s;
      r   = '0;
      if (s > 0) begin
         r.fwd = s[D-1:0];
      end else begin
         r.rev = neg[D-1:0];
      end
      return r;
   endfunction

   jddm_pkg::cfg_type cfg;

   logic out_ready, s1_ready, accept;
   logic enable_next;

   logic                            s1_valid_ff, s1_valid_in;
   logic [jddm_pkg::ADC_BITS-1:0]   s1_x_ff, s1_y_ff;
   logic                            s1_en_ff;

   logic signed [jddm_pkg::AXIS_W-1:0]    x_mapped, y_mapped;

   logic                            rsp_valid_ff, rsp_valid_in;
   jddm_pkg::rsp_type               rsp_ff, rsp_in;
   logic signed [jddm_pkg::MIX_W-1:0] left_sum, right_sum;
   side_type                        left_side, right_side;

   jddm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign req_stall = !s1_ready;
   assign accept    = req_valid && s1_ready;

   jddm_debounce u_debounce (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .time_ms      (req_payload.time_ms),
      .button_level (req_payload.button_level),
      .debounce_ms  (cfg.debounce_ms),
      .enable_next  (enable_next)
   );

   // input register
   assign s1_valid_in = s1_ready ? accept : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_x_ff  <= req_payload.joy_x;
         s1_y_ff  <= req_payload.joy_y;
         s1_en_ff <= enable_next;
      end
   end

   // map axes, mix, saturate, split
   jddm_axis u_axis_x (
      .raw            (s1_x_ff),
      .deadband_limit (cfg.deadband_limit),
      .mapped         (x_mapped)
   );

   jddm_axis u_axis_y (
      .raw            (s1_y_ff),
      .deadband_limit (cfg.deadband_limit),
      .mapped         (y_mapped)
   );

   always_comb begin
      left_sum  = jddm_pkg::MIX_W'(y_mapped) + jddm_pkg::MIX_W'(x_mapped);
      right_sum = jddm_pkg::MIX_W'(y_mapped) - jddm_pkg::MIX_W'(x_mapped);
      left_side  = split_side(left_sum);
      right_side = split_side(right_sum);
      rsp_in = '0;
      rsp_in.drive_enabled = s1_en_ff;
      if (s1_en_ff) begin
         rsp_in.left_forward  = left_side.fwd;
         rsp_in.left_reverse  = left_side.rev;
         rsp_in.right_forward = right_side.fwd;
         rsp_in.right_reverse = right_side.rev;
      end
   end

   assign rsp_valid_in = out_ready ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (out_ready && s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_disabled_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.drive_enabled) |->
         (rsp_payload.left_forward == '0 && rsp_payload.left_reverse == '0 &&
          rsp_payload.right_forward == '0 && rsp_payload.right_reverse == '0))
      else $error("nonzero duty while drive disabled");

   a_left_one_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.left_forward == '0 || rsp_payload.left_reverse == '0))
      else $error("left side driven both ways");

   a_right_one_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.right_forward == '0 || rsp_payload.right_reverse == '0))
      else $error("right side driven both ways");

   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |-> !accept)
      else $error("beat accepted into a full pipeline");

endmodule

// ===== dv/joystick_differential_drive_mixer_checker.sv =====
// Checker for the joystick drive mixer: tracks debounce and enable, predicts and compares duties.
module joystick_differential_drive_mixer_checker
   import jddm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    mix_errors,
   output int                    results_seen,
   output int                    duty_backlog,
   output int                    toggles_seen,
   output int                    enabled_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [DEBOUNCE_W-1:0] debounce_q = DEBOUNCE_RESET;
   logic [DEADBAND_W-1:0] deadband_q = DEADBAND_RESET;
   logic                  prev_level_q = 1'b1;
   logic                  stable_level_q = 1'b1;
   logic                  enable_q = 1'b0;
   logic [TIME_W-1:0]     last_edge_ms = '0;
   rsp_type               duty_expect_q[$];

   function automatic int scale_axis(logic [ADC_BITS-1:0] raw);
      int r;
      int m;
      r = raw;
      m = (r * 2 * DMAX) / AMAX - DMAX;
      if ((m < 0 ? -m : m) <= int'(deadband_q)) m = 0;
      return m;
   endfunction

   function automatic int clamp_mix(int v);
      if (v > DMAX) return DMAX;
      if (v < -DMAX) return -DMAX;
      return v;
   endfunction

   function automatic rsp_type predict_duties(req_type s);
      rsp_type d;
      int x;
      int y;
      int left;
      int right;
      d = '0;
      if (s.button_level != prev_level_q) last_edge_ms = s.time_ms;
      if (TIME_W'(s.time_ms - last_edge_ms) > debounce_q && s.button_level != stable_level_q) begin
         stable_level_q = s.button_level;
         if (!stable_level_q) begin
            enable_q = ~enable_q;
            toggles_seen++;
         end
      end
      prev_level_q = s.button_level;
      if (enable_q) begin
         enabled_seen++;
         x = scale_axis(s.joy_x);
         y = scale_axis(s.joy_y);
         left  = clamp_mix(y + x);
         right = clamp_mix(y - x);
         if (left > 0) d.left_forward = DUTY_BITS'(left);
         else d.left_reverse = DUTY_BITS'(-left);
         if (right > 0) d.right_forward = DUTY_BITS'(right);
         else d.right_reverse = DUTY_BITS'(-right);
      end
      d.drive_enabled = enable_q;
      return d;
   endfunction

   task automatic compare_field(string field, int want, int got);
      if (want != got) begin
         mix_errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         debounce_q     = DEBOUNCE_RESET;
         deadband_q     = DEADBAND_RESET;
         prev_level_q   = 1'b1;
         stable_level_q = 1'b1;
         enable_q       = 1'b0;
         last_edge_ms   = '0;
         duty_expect_q.delete();
         mix_errors     = 0;
         results_seen   = 0;
         toggles_seen   = 0;
         enabled_seen   = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[CSR_ADDR_W-1:2] == REG_DEBOUNCE)
               debounce_q = csr_pwdata[DEBOUNCE_W-1:0];
            else if (csr_paddr[CSR_ADDR_W-1:2] == REG_DEADBAND)
               deadband_q = csr_pwdata[DEADBAND_W-1:0];
         end
         if (req_valid && !req_stall)
            duty_expect_q.push_back(predict_duties(req_payload));
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (duty_expect_q.size() == 0) begin
               mix_errors++;
               $display("%0t: duty beat with none expected, got %h", $time, rsp_payload);
            end else begin
               want = duty_expect_q.pop_front();
               compare_field("left_forward", want.left_forward, rsp_payload.left_forward);
               compare_field("left_reverse", want.left_reverse, rsp_payload.left_reverse);
               compare_field("right_forward", want.right_forward, rsp_payload.right_forward);
               compare_field("right_reverse", want.right_reverse, rsp_payload.right_reverse);
               compare_field("drive_enabled", want.drive_enabled, rsp_payload.drive_enabled);
            end
         end
      end
      duty_backlog = duty_expect_q.size();
   end

endmodule

// ===== dv/joystick_differential_drive_mixer_core_tb.sv =====
// Testbench top: drives samples and register writes into the mixer and reports the verdict.
module joystick_differential_drive_mixer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import jddm_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int PHASES     = 6;

   typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int mix_errors;
   int results_seen;
   int duty_backlog;
   int toggles_seen;
   int enabled_seen;

   int samples_sent = 0;
   int burst_left = 0;
   int idle_cycles = 0;
   int stall_span = 0;
   int stall_phase = 0;
   stall_mode_e stall_mode = STALL_NONE;

   logic [TIME_W-1:0] t_now = '0;
   logic              level_now = 1'b1;
   int                hold_left = 0;
   int                step_max = 13;

   joystick_differential_drive_mixer_core u_dut (.*);

   joystick_differential_drive_mixer_checker u_mix_check (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver backpressure switches at random among none, light, heavy and periodic stall modes
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode <= stall_mode_e'($urandom_range(0, 3));
         stall_span <= $urandom_range(32, 256);
      end else begin
         stall_span <= stall_span - 1;
      end
      stall_phase <= stall_phase + 1;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 4) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) != 0);
         default:     rsp_stall <= (stall_phase % 5) < 2;
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_sample(input req_type s);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if ($urandom_range(0, 15) == 0) gap = $urandom_range(13, 40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= s;
      do @(posedge clock); while (req_stall);
      samples_sent++;
   endtask

   task automatic send_fields(input logic [TIME_W-1:0] t, input logic lvl,
                              input int x, input int y);
      req_type s;
      s.time_ms      = t;
      s.button_level = lvl;
      s.joy_x        = ADC_BITS'(x);
      s.joy_y        = ADC_BITS'(y);
      send_sample(s);
   endtask

   task automatic csr_write(input logic reg_sel, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_duties();
      req_valid <= 1'b0;
      wait (results_seen == samples_sent);
      @(posedge clock);
   endtask

   function automatic logic [ADC_BITS-1:0] pick_axis();
      case ($urandom_range(0, 7))
         0:       return $urandom_range(0, 1) ? ADC_BITS'(AMAX) : '0;
         1, 2:    return ADC_BITS'($urandom_range(AMAX / 2 - 300, AMAX / 2 + 300));
         default: return ADC_BITS'($urandom_range(0, AMAX));
      endcase
   endfunction

   // held button levels with random hold lengths, occasional bounces and time jumps
   function automatic req_type make_sample();
      req_type s;
      if (hold_left == 0) begin
         level_now = ~level_now;
         hold_left = $urandom_range(1, 12);
      end
      hold_left--;
      case ($urandom_range(0, 49))
         0:       t_now = $urandom;
         1:       t_now = 32'hFFFF_FFFF - $urandom_range(0, 40);
         default: t_now = t_now + $urandom_range(0, step_max);
      endcase
      s.time_ms      = t_now;
      s.button_level = level_now ^ ($urandom_range(0, 29) == 0);
      s.joy_x        = pick_axis();
      s.joy_y        = pick_axis();
      return s;
   endfunction

   initial begin
      logic [DEBOUNCE_W-1:0] debounce_set [PHASES];
      logic [DEADBAND_W-1:0] deadband_set [PHASES];
      int per_phase;

      debounce_set = '{16'd30, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd30};
      deadband_set = '{8'd20, 8'd0, 8'hFF, 8'd0, 8'd0, 8'd20};
      debounce_set[3] = DEBOUNCE_W'($urandom_range(1, 500));
      deadband_set[3] = DEADBAND_W'($urandom_range(0, 255));
      debounce_set[4] = DEBOUNCE_W'($urandom);
      deadband_set[4] = DEADBAND_W'($urandom);
      per_phase = 2000 / PHASES;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // disabled, then a press held past the debounce window
      send_fields(32'd10, 1'b1, 0, 0);
      send_fields(32'd50, 1'b0, 4095, 4095);
      send_fields(32'd70, 1'b0, 4095, 0);
      send_fields(32'd81, 1'b0, 2048, 2048);
      // saturation and zero mix on each side
      send_fields(32'd82, 1'b0, 0, 0);
      send_fields(32'd83, 1'b0, 4095, 4095);
      send_fields(32'd84, 1'b0, 4095, 0);
      send_fields(32'd85, 1'b0, 0, 4095);
      // deadband edges on both signs
      send_fields(32'd86, 1'b0, 2209, 1887);
      send_fields(32'd87, 1'b0, 2217, 1878);
      send_fields(32'd88, 1'b0, 2047, 2048);
      // release accepted, no toggle
      send_fields(32'd100, 1'b1, 3000, 1000);
      send_fields(32'd140, 1'b1, 1000, 3000);
      // bounce shorter than the window
      send_fields(32'd150, 1'b0, 3500, 3500);
      send_fields(32'd155, 1'b1, 500, 3500);
      send_fields(32'd200, 1'b1, 3500, 500);
      // second press disables
      send_fields(32'd300, 1'b0, 4095, 4095);
      send_fields(32'd331, 1'b0, 4095, 4095);
      // release and press across the timestamp wrap
      send_fields(32'hFFFF_FFF0, 1'b1, 4095, 2048);
      send_fields(32'h0000_0010, 1'b1, 4095, 2048);
      send_fields(32'h0000_0020, 1'b0, 4095, 2048);
      send_fields(32'h0000_0040, 1'b0, 4095, 2048);
      send_fields(32'h0000_0041, 1'b0, 0, 2048);
      t_now = 32'h0000_0041;

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            drain_duties();
            csr_write(REG_DEBOUNCE, CSR_DATA_W'(debounce_set[p]));
            csr_write(REG_DEADBAND, CSR_DATA_W'(deadband_set[p]));
         end
         step_max = debounce_set[p] / 3 + 3;
         for (int i = 0; i < per_phase; i++) send_sample(make_sample());
      end

      drain_duties();
      repeat (8) @(posedge clock);

      $display("Sent %0d samples over %0d register settings, %0d duty beats checked.",
               samples_sent, PHASES, results_seen);
      $display("Enable toggled %0d times, %0d samples mixed while enabled.",
               toggles_seen, enabled_seen);
      if (mix_errors == 0 && duty_backlog == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d duty beats still expected", mix_errors, duty_backlog);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
